/* sv/hts_pkg.sv */
package hts_pkg;

    // Item kinds.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_FORCE  = 2'd2;

    // Mode codes, shared by the force request and the result.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_HEAT = 2'd1;
    localparam logic [1:0] MODE_COOL = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FORCED_HEAT = 3'd0;
    localparam logic [2:0] CFG_FORCED_COOL = 3'd1;
    localparam logic [2:0] CFG_HEAT_OFF    = 3'd2;
    localparam logic [2:0] CFG_COOL_OFF    = 3'd3;
    localparam logic [2:0] CFG_HEAT_ON     = 3'd4;
    localparam logic [2:0] CFG_COOL_ON     = 3'd5;
    localparam logic [2:0] CFG_LOW_LIMIT   = 3'd6;
    localparam logic [2:0] CFG_HIGH_LIMIT  = 3'd7;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned ELAPSED_W  = 17;

    localparam logic [ELAPSED_W-1:0] MS_PER_HALFSEC = 17'd500;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [11:0] temperature;
        logic [1:0]         force_mode;
    } t_in_word;

    typedef struct packed {
        logic [1:0] mode;
        logic       forced;
        logic       force_done;
    } t_out_word;

    typedef struct packed {
        logic [7:0] forced_heat_halfsec;
        logic [7:0] forced_cool_halfsec;
        logic [7:0] heat_off_hyst_half;
        logic [7:0] cool_off_hyst_half;
        logic [7:0] heat_on_hyst_half;
        logic [7:0] cool_on_hyst_half;
        logic [7:0] low_limit_deg;
        logic [7:0] high_limit_deg;
    } t_cfg;

endpackage

/* sv/hts_cfg.sv */
module hts_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hts_pkg::t_cfg                  o_cfg
);

    hts_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forced_heat_halfsec <= 8'd10;
            r_cfg.forced_cool_halfsec <= 8'd10;
            r_cfg.heat_off_hyst_half  <= 8'd4;
            r_cfg.cool_off_hyst_half  <= 8'd4;
            r_cfg.heat_on_hyst_half   <= 8'd2;
            r_cfg.cool_on_hyst_half   <= 8'd2;
            r_cfg.low_limit_deg       <= 8'd24;
            r_cfg.high_limit_deg      <= 8'd27;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hts_pkg::CFG_FORCED_HEAT: r_cfg.forced_heat_halfsec <= i_cfg_data;
                hts_pkg::CFG_FORCED_COOL: r_cfg.forced_cool_halfsec <= i_cfg_data;
                hts_pkg::CFG_HEAT_OFF:    r_cfg.heat_off_hyst_half  <= i_cfg_data;
                hts_pkg::CFG_COOL_OFF:    r_cfg.cool_off_hyst_half  <= i_cfg_data;
                hts_pkg::CFG_HEAT_ON:     r_cfg.heat_on_hyst_half   <= i_cfg_data;
                hts_pkg::CFG_COOL_ON:     r_cfg.cool_on_hyst_half   <= i_cfg_data;
                hts_pkg::CFG_LOW_LIMIT:   r_cfg.low_limit_deg       <= i_cfg_data;
                hts_pkg::CFG_HIGH_LIMIT:  r_cfg.high_limit_deg      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/hts_ctrl.sv */
module hts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  hts_pkg::t_in_word  i_word,
    input  hts_pkg::t_cfg      i_cfg,
    output hts_pkg::t_out_word o_result
);

    logic [1:0]                    r_mode;
    logic                          r_forced;
    logic [hts_pkg::ELAPSED_W-1:0] r_elapsed;

    logic [1:0]                    n_mode;
    logic                          n_forced;
    logic [hts_pkg::ELAPSED_W-1:0] n_elapsed;
    logic                          w_done;

    logic signed [13:0] w_t;
    logic signed [13:0] w_lo;
    logic signed [13:0] w_hi;
    logic signed [13:0] w_cool_on_th;
    logic signed [13:0] w_heat_on_th;
    logic signed [13:0] w_heat_off_th;
    logic signed [13:0] w_cool_off_th;
    logic [7:0]                    w_dur_half;
    logic [hts_pkg::ELAPSED_W-1:0] w_dur;
    logic [hts_pkg::ELAPSED_W-1:0] w_elapsed_inc;

    // Limits are whole degrees (x16), hysteresis half degrees (x8); all fit 14 bits signed.
    assign w_t  = {{2{i_word.temperature[11]}}, i_word.temperature};
    assign w_lo = $signed({2'b00, i_cfg.low_limit_deg, 4'b0000});
    assign w_hi = $signed({2'b00, i_cfg.high_limit_deg, 4'b0000});
    assign w_cool_on_th  = w_hi + $signed({3'b000, i_cfg.cool_on_hyst_half, 3'b000});
    assign w_heat_on_th  = w_lo - $signed({3'b000, i_cfg.heat_on_hyst_half, 3'b000});
    assign w_heat_off_th = w_lo + $signed({3'b000, i_cfg.heat_off_hyst_half, 3'b000});
    assign w_cool_off_th = w_hi - $signed({3'b000, i_cfg.cool_off_hyst_half, 3'b000});

    assign w_dur_half = (r_mode == hts_pkg::MODE_COOL) ? i_cfg.forced_cool_halfsec
                                                       : i_cfg.forced_heat_halfsec;
    assign w_dur = hts_pkg::ELAPSED_W'({9'd0, w_dur_half} * hts_pkg::MS_PER_HALFSEC);
    assign w_elapsed_inc = (r_elapsed < hts_pkg::ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;

    always_comb begin
        n_mode    = r_mode;
        n_forced  = r_forced;
        n_elapsed = r_elapsed;
        w_done    = 1'b0;
        case (i_word.opcode)
            hts_pkg::OP_SAMPLE: begin
                if (!r_forced) begin
                    case (r_mode)
                        hts_pkg::MODE_IDLE: begin
                            if (!(w_t < w_hi && w_t > w_lo)) begin
                                if (w_t > w_cool_on_th) begin
                                    n_mode = hts_pkg::MODE_COOL;
                                end else if (w_t < w_heat_on_th) begin
                                    n_mode = hts_pkg::MODE_HEAT;
                                end
                            end
                        end
                        hts_pkg::MODE_HEAT: begin
                            if (w_t > w_heat_off_th) begin
                                n_mode = hts_pkg::MODE_IDLE;
                            end
                        end
                        hts_pkg::MODE_COOL: begin
                            if (w_t < w_cool_off_th) begin
                                n_mode = hts_pkg::MODE_IDLE;
                            end
                        end
                        default: n_mode = hts_pkg::MODE_IDLE;
                    endcase
                end
            end
            hts_pkg::OP_TICK: begin
                if (r_forced) begin
                    n_elapsed = w_elapsed_inc;
                    if (w_elapsed_inc >= w_dur) begin
                        n_forced = 1'b0;
                        w_done   = 1'b1;
                    end
                end
            end
            hts_pkg::OP_FORCE: begin
                if (i_word.force_mode == hts_pkg::MODE_HEAT ||
                    i_word.force_mode == hts_pkg::MODE_COOL) begin
                    n_mode    = i_word.force_mode;
                    n_forced  = 1'b1;
                    n_elapsed = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= hts_pkg::MODE_IDLE;
            r_forced  <= 1'b0;
            r_elapsed <= '0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_forced  <= n_forced;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_result.mode       = n_mode;
    assign o_result.forced     = n_forced;
    assign o_result.force_done = w_done;

    a_done_clears_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_done) |=> !r_forced)
        else $error("forced flag still set after the forced period expired");

    a_forced_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_forced && !(i_fire && i_word.opcode == hts_pkg::OP_FORCE)) |=> !r_forced)
        else $error("forced flag set without a force request");

    a_request_restarts_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_word.opcode == hts_pkg::OP_FORCE &&
         (i_word.force_mode == hts_pkg::MODE_HEAT ||
          i_word.force_mode == hts_pkg::MODE_COOL))
        |=> (r_forced && r_elapsed == '0 && r_mode == $past(i_word.force_mode)))
        else $error("force request did not restart the timer");

    a_no_tick_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_word.opcode == hts_pkg::OP_TICK && !r_forced)
        |=> $stable(r_elapsed))
        else $error("timer moved while no forced period ran");

endmodule

/* sv/hysteresis_thermostat_controller.sv */
// Three-mode hysteresis thermostat. Each input word is a temperature sample (sixteenths of a
// degree), a millisecond tick or a force request, and each yields exactly one result word
// with the mode after the item, the forced flag and a one-shot force_done on the expiring
// tick. Words pass an input register and a result register with the state update between
// them, so the block takes one word per clock while the output is not stalled; the result
// word is registered as its input word fires, and a full, stalled result register stalls the
// input. Configuration registers must be written through the plain write port only while
// no word is in flight; the block itself does not enforce this.
module hysteresis_thermostat_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hts_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hts_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    hts_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    hts_pkg::t_out_word r_out_word;

    logic               w_advance;
    logic               w_fire;
    hts_pkg::t_cfg      w_cfg;
    hts_pkg::t_out_word w_result;

    // The held word moves on whenever the result register is empty or being drained.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    hts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    hts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_word   (r_in_word),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_fire) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* test/tb_hysteresis_thermostat_controller.sv */
`timescale 1ns / 100ps

module tb_hysteresis_thermostat_controller;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] FORCE_BAD   = 2'd3;
    localparam int unsigned HALFSEC_MS = 500;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // Threshold selectors for the shadow model.
    localparam int unsigned TH_LOW      = 0;
    localparam int unsigned TH_HIGH     = 1;
    localparam int unsigned TH_HEAT_ON  = 2;
    localparam int unsigned TH_HEAT_OFF = 3;
    localparam int unsigned TH_COOL_ON  = 4;
    localparam int unsigned TH_COOL_OFF = 5;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           o_in_stall;
    hts_pkg::t_in_word              in_word = '0;
    logic                           o_out_valid;
    logic                           out_stall = 1'b0;
    hts_pkg::t_out_word             o_out_word;
    logic                           cfg_we = 1'b0;
    logic [hts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    hysteresis_thermostat_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shadow copy of the thermostat: settings, mode, forced flag and force timer.
    hts_pkg::t_cfg cfg_model;
    logic [1:0]    mode_q = hts_pkg::MODE_IDLE;
    logic          forced_q = 1'b0;
    logic [16:0]   elapsed_q = '0;

    hts_pkg::t_in_word  words_to_send[$];
    hts_pkg::t_out_word expected_status[$];
    int unsigned status_owed = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          idle_on = 1'b1;

    function automatic int threshold(int unsigned k);
        int lo;
        int hi;
        lo = int'(cfg_model.low_limit_deg) * 16;
        hi = int'(cfg_model.high_limit_deg) * 16;
        case (k)
            TH_LOW: return lo;
            TH_HIGH: return hi;
            TH_HEAT_ON: return lo - int'(cfg_model.heat_on_hyst_half) * 8;
            TH_HEAT_OFF: return lo + int'(cfg_model.heat_off_hyst_half) * 8;
            TH_COOL_ON: return hi + int'(cfg_model.cool_on_hyst_half) * 8;
            default: return hi - int'(cfg_model.cool_off_hyst_half) * 8;
        endcase
    endfunction

    function automatic hts_pkg::t_out_word predict_status(hts_pkg::t_in_word w);
        int                 t;
        int unsigned        dur_ms;
        hts_pkg::t_out_word r;
        t = int'(w.temperature);
        t = {{20{w.temperature[11]}}, w.temperature};
        r.force_done = 1'b0;
        case (w.opcode)
            hts_pkg::OP_SAMPLE: begin
                if (!forced_q) begin
                    case (mode_q)
                        hts_pkg::MODE_IDLE: begin
                            if (!(t < threshold(TH_HIGH) && t > threshold(TH_LOW))) begin
                                if (t > threshold(TH_COOL_ON))
                                    mode_q = hts_pkg::MODE_COOL;
                                else if (t < threshold(TH_HEAT_ON))
                                    mode_q = hts_pkg::MODE_HEAT;
                            end
                        end
                        hts_pkg::MODE_HEAT: begin
                            if (t > threshold(TH_HEAT_OFF))
                                mode_q = hts_pkg::MODE_IDLE;
                        end
                        hts_pkg::MODE_COOL: begin
                            if (t < threshold(TH_COOL_OFF))
                                mode_q = hts_pkg::MODE_IDLE;
                        end
                        default: mode_q = hts_pkg::MODE_IDLE;
                    endcase
                end
            end
            hts_pkg::OP_TICK: begin
                if (forced_q) begin
                    if (elapsed_q != '1)
                        elapsed_q = elapsed_q + 1'b1;
                    dur_ms = 32'(mode_q == hts_pkg::MODE_COOL ? cfg_model.forced_cool_halfsec
                                                              : cfg_model.forced_heat_halfsec)
                             * HALFSEC_MS;
                    if (32'(elapsed_q) >= dur_ms) begin
                        forced_q = 1'b0;
                        r.force_done = 1'b1;
                    end
                end
            end
            hts_pkg::OP_FORCE: begin
                if (w.force_mode == hts_pkg::MODE_HEAT || w.force_mode == hts_pkg::MODE_COOL) begin
                    mode_q = w.force_mode;
                    forced_q = 1'b1;
                    elapsed_q = '0;
                end
            end
            default: ;
        endcase
        r.mode = mode_q;
        r.forced = forced_q;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void send_word(logic [1:0] op, logic [11:0] temp, logic [1:0] fm);
        hts_pkg::t_in_word w;
        w.opcode = op;
        w.temperature = temp;
        w.force_mode = fm;
        words_to_send.push_back(w);
        status_owed++;
    endfunction

    function automatic void sample(int t);
        send_word(hts_pkg::OP_SAMPLE, 12'(t), 2'($urandom));
    endfunction

    function automatic void tick();
        send_word(hts_pkg::OP_TICK, 12'($urandom), 2'($urandom));
    endfunction

    function automatic void force_req(logic [1:0] fm);
        send_word(hts_pkg::OP_FORCE, 12'($urandom), fm);
    endfunction

    function automatic logic [7:0] random_hyst();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(0, 8));
        if (r < 80)
            return 8'($urandom);
        return (r < 90) ? 8'd0 : 8'd255;
    endfunction

    function automatic logic [7:0] random_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'd0;
        if (r < 80)
            return 8'd1;
        return 8'($urandom_range(2, 255));
    endfunction

    function automatic hts_pkg::t_cfg random_config();
        hts_pkg::t_cfg c;
        c.forced_heat_halfsec = random_duration();
        c.forced_cool_halfsec = random_duration();
        c.heat_off_hyst_half = random_hyst();
        c.cool_off_hyst_half = random_hyst();
        c.heat_on_hyst_half = random_hyst();
        c.cool_on_hyst_half = random_hyst();
        if ($urandom_range(0, 99) < 15) begin
            c.low_limit_deg = 8'($urandom);
            c.high_limit_deg = 8'($urandom);
        end else begin
            c.low_limit_deg = 8'($urandom_range(0, 60));
            c.high_limit_deg = c.low_limit_deg + 8'($urandom_range(0, 20));
        end
        return c;
    endfunction

    task automatic put_reg(logic [hts_pkg::CFG_IDX_W-1:0] idx,
                           logic [hts_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(hts_pkg::t_cfg c);
        cfg_model = c;
        put_reg(hts_pkg::CFG_FORCED_HEAT, c.forced_heat_halfsec);
        put_reg(hts_pkg::CFG_FORCED_COOL, c.forced_cool_halfsec);
        put_reg(hts_pkg::CFG_HEAT_OFF, c.heat_off_hyst_half);
        put_reg(hts_pkg::CFG_COOL_OFF, c.cool_off_hyst_half);
        put_reg(hts_pkg::CFG_HEAT_ON, c.heat_on_hyst_half);
        put_reg(hts_pkg::CFG_COOL_ON, c.cool_on_hyst_half);
        put_reg(hts_pkg::CFG_LOW_LIMIT, c.low_limit_deg);
        put_reg(hts_pkg::CFG_HIGH_LIMIT, c.high_limit_deg);
    endtask

    // The sender holds off until every status word has come back, then lets the
    // two pipeline stages settle before anything else happens.
    task automatic wait_all_status();
        while (status_owed != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                expected_status.push_back(predict_status(in_word));
            if (in_valid && o_in_stall) begin
                // Hold the stalled word.
            end else if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                in_word <= words_to_send.pop_front();
                in_valid <= 1'b1;
                gap_left = idle_on ? pick_gap() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        hts_pkg::t_out_word want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_status.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("status word with none expected: mode %0d forced %0d done %0d",
                                 o_out_word.mode, o_out_word.forced, o_out_word.force_done);
                end else begin
                    want = expected_status.pop_front();
                    status_owed--;
                    if (o_out_word.mode !== want.mode || o_out_word.forced !== want.forced ||
                        o_out_word.force_done !== want.force_done) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"status mismatch: expected mode %0d forced %0d done %0d,",
                                      " got mode %0d forced %0d done %0d"},
                                     want.mode, want.forced, want.force_done,
                                     o_out_word.mode, o_out_word.forced,
                                     o_out_word.force_done);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        hts_pkg::t_cfg c;
        int unsigned   n;
        int unsigned   r;
        int unsigned   run_len;
        logic [7:0]    dur;
        logic [1:0]    fm;
        cfg_model = '{8'd10, 8'd10, 8'd4, 8'd4, 8'd2, 8'd2, 8'd24, 8'd27};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings out of reset: low 384, high 432, hysteresis 16 on and 32 off.
        sample(448);
        sample(449);
        sample(400);
        sample(399);
        sample(368);
        sample(367);
        sample(416);
        sample(417);
        sample(2047);
        sample(-2048);
        send_word(OP_UNUSED, 12'($urandom), 2'($urandom));
        tick();
        force_req(hts_pkg::MODE_IDLE);
        force_req(FORCE_BAD);
        force_req(hts_pkg::MODE_HEAT);
        sample(-880);
        force_req(hts_pkg::MODE_COOL);
        wait_all_status();

        // Everything zero: a forced period ends on the first tick.
        c = '0;
        load_config(c);
        force_req(hts_pkg::MODE_HEAT);
        tick();
        sample(1);
        sample(-1);
        force_req(hts_pkg::MODE_COOL);
        tick();
        wait_all_status();

        // Crossed limits (low 255, high 0) with every other setting at its maximum, then a
        // half-second forced period run out tick by tick.
        c = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0};
        load_config(c);
        sample(2047);
        sample(-2048);
        sample(0);
        sample(2047);
        wait_all_status();
        c.forced_heat_halfsec = 8'd1;
        c.forced_cool_halfsec = 8'd1;
        load_config(c);
        idle_on = 1'b0;
        force_req(hts_pkg::MODE_COOL);
        repeat (HALFSEC_MS + 1) tick();
        force_req(hts_pkg::MODE_HEAT);
        repeat (3) tick();
        wait_all_status();

        for (int ph = 0; ph < 8; ph++) begin
            c = random_config();
            load_config(c);
            idle_on = (ph != 2);
            n = 0;
            while (n < 35) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    if ($urandom_range(0, 99) < 85)
                        sample(threshold($urandom_range(TH_LOW, TH_COOL_OFF)) +
                               int'($urandom_range(0, 4)) - 2);
                    else
                        sample(int'($urandom));
                    n++;
                end else if (r < 70) begin
                    tick();
                    n++;
                end else if (r < 82) begin
                    fm = $urandom_range(0, 1) ? hts_pkg::MODE_COOL : hts_pkg::MODE_HEAT;
                    force_req(fm);
                    n++;
                    dur = (fm == hts_pkg::MODE_COOL) ? c.forced_cool_halfsec
                                                     : c.forced_heat_halfsec;
                    // Run a zero-length forced period out, stopping short of, at, or just
                    // past its end.
                    if (dur == 0 && $urandom_range(0, 1) == 1) begin
                        run_len = $urandom_range(0, 2);
                        repeat (run_len) begin
                            if ($urandom_range(0, 99) == 0)
                                sample(threshold($urandom_range(TH_LOW, TH_COOL_OFF)));
                            tick();
                            n++;
                        end
                    end
                end else if (r < 88) begin
                    force_req($urandom_range(0, 1) ? FORCE_BAD : hts_pkg::MODE_IDLE);
                    n++;
                end else if (r < 94) begin
                    send_word(OP_UNUSED, 12'($urandom), 2'($urandom));
                    n++;
                end else begin
                    // One full heat and cool cycle, each sample just past its threshold.
                    sample(threshold(TH_HEAT_ON) - 1);
                    sample(threshold(TH_HEAT_OFF) + 1);
                    sample(threshold(TH_COOL_ON) + 1);
                    sample(threshold(TH_COOL_OFF) - 1);
                    n += 4;
                end
            end
            wait_all_status();
        end

        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
